// File: sv/sha256_message_digest_macros.svh
// Assertion macros for the SHA-256 message digest block.
// Used by the port checker; expects clk and rst in scope.
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SMD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smd check failed");

// Next-cycle implication, disabled in reset.
`define SMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smd check failed");

`endif

// File: sv/smd_pkg.sv
// Shared types, constants and tables for the SHA-256 message digest block.
// No dependencies.
package smd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ZERO, ST_LEN, ST_RND, ST_ADD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_DATA, SEL_PAD, SEL_ZERO
  } byte_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic      wr;
    byte_sel_t sel;
    logic      cnt_total;
    logic      wr_len;
    logic      round;
    logic [5:0] rnd;
    logic      fold;
    logic      restart;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [5:0] fill;
  } sts_t;

  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] RND_LAST  = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    return K_TABLE[idx];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// File: sv/sha256_message_digest.sv
// SHA-256 message digest over a byte stream: top level.
// Depends on smd_pkg, smd_ctrl and smd_dpath.
//
//  channel | signals                           | transaction
//  --------+-----------------------------------+--------------------------------
//  item    | item_valid, item_ready, item      | one optional byte + end flag
//  digest  | digest_valid, digest_ready, digest| one 32-bit digest word (8/msg)
//
// Flow: a byte that does not complete a block is only stored. A byte that
// completes a 64-byte block adds 64 compression rounds and a fold.
// An end transaction then runs padding one byte per cycle (pausing for an
// extra 64 rounds and fold when the length spills into a second block),
// a length write, 64 rounds, a fold, and 8 digest transactions. The
// 64-round compression loop sets the rate.
// Reset (rst, synchronous) loads the initial hash values, clears counters.
// item_ready is low while compressing, padding or emitting; a stalled
// digest word is held until taken.
module sha256_message_digest (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  smd_pkg::item_t     item,
  output logic               digest_valid,
  input  logic               digest_ready,
  output smd_pkg::digest_t   digest
);
  import smd_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] widx;
  logic [31:0] word;

  smd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .has_byte     (item.has_byte),
    .is_last      (item.is_last),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .word_index   (widx),
    .sts          (sts),
    .cmd          (cmd)
  );

  smd_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (item.data_byte),
    .cmd         (cmd),
    .word_index  (widx),
    .sts         (sts),
    .digest_word (word)
  );

  // digest words come straight from the hash registers, stable while held
  assign digest.digest_word = word;
  assign digest.word_index  = widx;
  assign digest.last_word   = (widx == WORD_LAST);

endmodule

// File: sv/smd_dpath.sv
// SHA-256 datapath: block/schedule window, working variables, hash words.
// Depends on smd_pkg; driven by smd_ctrl commands.
module smd_dpath (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       data_byte,
  input  smd_pkg::cmd_t    cmd,
  input  logic [2:0]       word_index,
  output smd_pkg::sts_t    sts,
  output logic [31:0]      digest_word
);
  import smd_pkg::*;

  logic [31:0] blk [16];   // message block, reused as schedule window
  logic [31:0] v   [8];    // a..h
  logic [31:0] hw  [8];
  logic [5:0]  fill;
  logic [63:0] total;

  logic [7:0]  wr_byte;
  logic [63:0] bit_len;
  logic [31:0] w_new, s0, s1, t1, t2, big_s0, big_s1, ch, maj;

  always_comb begin
    case (cmd.sel)
      SEL_DATA: wr_byte = data_byte;
      SEL_PAD:  wr_byte = PAD_BYTE;
      default:  wr_byte = 8'h00;
    endcase
    bit_len = {total[60:0], 3'b000};
    s0      = rotr(blk[1], 7) ^ rotr(blk[1], 18) ^ (blk[1] >> 3);
    s1      = rotr(blk[14], 17) ^ rotr(blk[14], 19) ^ (blk[14] >> 10);
    w_new   = blk[0] + s0 + blk[9] + s1;
    big_s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch      = (v[4] & v[5]) ^ (~v[4] & v[6]);
    big_s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj     = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1      = v[7] + big_s1 + ch + round_k(cmd.rnd) + blk[0];
    t2      = big_s0 + maj;
  end

  // block window
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_byte;
    end else if (cmd.wr_len) begin
      blk[14] <= bit_len[63:32];
      blk[15] <= bit_len[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) blk[i] <= blk[i+1];
      blk[15] <= w_new;
    end
  end

  // working variables track the hash words whenever no round is running
  always_ff @(posedge clk) begin
    if (cmd.round) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end else begin
      for (int i = 0; i < 8; i++) v[i] <= hw[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < 8; i++) hw[i] <= H_INIT[i];
      fill  <= '0;
      total <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) hw[i] <= hw[i] + v[i];
      end
      if (cmd.wr) fill <= fill + 6'd1;
      if (cmd.cnt_total) total <= total + 64'd1;
    end
  end

  assign sts.fill    = fill;
  assign digest_word = hw[word_index];

endmodule

// File: sv/smd_ctrl.sv
// SHA-256 sequencer: intake, padding, round count, digest output.
// Depends on smd_pkg; drives smd_dpath.
module smd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic             has_byte,
  input  logic             is_last,
  output logic             digest_valid,
  input  logic             digest_ready,
  output logic [2:0]       word_index,
  input  smd_pkg::sts_t    sts,
  output smd_pkg::cmd_t    cmd
);
  import smd_pkg::*;

  state_t     state, state_next, after, after_next;
  logic [5:0] rnd;
  logic [2:0] widx;

  always_comb begin
    state_next = state;
    after_next = after;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (has_byte && sts.fill == FILL_LAST) begin
            state_next = ST_RND;
            after_next = is_last ? ST_PAD : ST_IDLE;
          end else if (is_last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (sts.fill == FILL_LAST) begin
          state_next = ST_RND;
          after_next = ST_ZERO;
        end else begin
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (sts.fill == LEN_START) begin
          state_next = ST_LEN;
        end else if (sts.fill == FILL_LAST) begin
          state_next = ST_RND;
          after_next = ST_ZERO;
        end
      end
      ST_LEN: begin
        state_next = ST_RND;
        after_next = ST_OUT;
      end
      ST_RND:  if (rnd == RND_LAST) state_next = ST_ADD;
      ST_ADD:  state_next = after;
      ST_OUT:  if (digest_ready && widx == WORD_LAST) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready    = 1'b0;
    digest_valid  = 1'b0;
    cmd           = '0;
    cmd.sel       = SEL_DATA;
    cmd.rnd       = rnd;
    unique case (state)
      ST_IDLE: begin
        item_ready    = 1'b1;
        cmd.wr        = item_valid && has_byte;
        cmd.cnt_total = item_valid && has_byte;
      end
      ST_PAD: begin
        cmd.wr  = 1'b1;
        cmd.sel = SEL_PAD;
      end
      ST_ZERO: begin
        cmd.wr  = (sts.fill != LEN_START);
        cmd.sel = SEL_ZERO;
      end
      ST_LEN:  cmd.wr_len = 1'b1;
      ST_RND:  cmd.round  = 1'b1;
      ST_ADD:  cmd.fold   = 1'b1;
      ST_OUT: begin
        digest_valid = 1'b1;
        cmd.restart  = digest_ready && widx == WORD_LAST;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      after <= ST_IDLE;
      rnd   <= '0;
      widx  <= '0;
    end else begin
      state <= state_next;
      after <= after_next;
      rnd   <= (state == ST_RND) ? rnd + 6'd1 : 6'd0;
      if (digest_valid && digest_ready) widx <= widx + 3'd1;
    end
  end

  assign word_index = widx;

endmodule

// File: sv/smd_checker.sv
// Port-level checks for sha256_message_digest, bound to the top level.
// Depends on smd_pkg and sha256_message_digest_macros.svh.
`include "sha256_message_digest_macros.svh"
module smd_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             digest_valid,
  input logic             digest_ready,
  input smd_pkg::digest_t digest
);
  import smd_pkg::*;

  logic       d_take;
  logic       mid_take;
  logic [2:0] idx_inc;

  assign d_take   = digest_valid && digest_ready;
  assign mid_take = d_take && !digest.last_word;
  assign idx_inc  = digest.word_index + 3'd1;

  `SMD_ASSERT_NEXT(a_hold, digest_valid && !digest_ready, digest_valid && $stable(digest))
  `SMD_ASSERT_NOW(a_no_intake, digest_valid, !item_ready)
  `SMD_ASSERT_NEXT(a_end_msg, d_take && digest.last_word, !digest_valid)
  `SMD_ASSERT_NEXT(a_word_seq, mid_take, digest_valid && digest.word_index == $past(idx_inc))

endmodule

bind sha256_message_digest smd_checker u_smd_checker (.*);
